/* rtl/core/tstl_pkg.sv */
package tstl_pkg;

    localparam int IDX_W        = 32;
    localparam int VCOUNT_W     = 31;
    localparam int CFG_IDX_W    = 1;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET  = 1'b1;

    // one triangle in output order, already rewound for odd positions
    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
    } t_vtx;

    typedef struct packed {
        logic valid;
        t_vtx vtx;
    } t_push;

    typedef struct packed {
        logic avail;
        t_vtx vtx;
    } t_head;

endpackage

/* rtl/core/tstl_front.sv */
module tstl_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [tstl_pkg::IDX_W-1:0]         i_vertex_index,
    input  logic                               i_strip_start,
    input  logic [tstl_pkg::VCOUNT_W-1:0]      i_vertex_count,
    output tstl_pkg::t_push                    o_push
);

    logic [tstl_pkg::IDX_W-1:0] r_older, n_older;
    logic [tstl_pkg::IDX_W-1:0] r_newer, n_newer;
    logic [1:0]                 r_fill, n_fill;
    logic                       r_odd, n_odd;

    logic [1:0] w_fill;
    logic       w_odd;
    logic       w_dup;
    logic       w_range;
    logic       w_keep;

    function automatic logic index_ok(input logic [tstl_pkg::IDX_W-1:0] v,
                                      input logic [tstl_pkg::VCOUNT_W-1:0] cnt);
        index_ok = !v[tstl_pkg::IDX_W-1] && (v[tstl_pkg::VCOUNT_W-1:0] < cnt);
    endfunction

    always_comb begin
        // a strip start forgets the window and the parity
        w_fill  = i_strip_start ? 2'd0 : r_fill;
        w_odd   = i_strip_start ? 1'b0 : r_odd;
        w_dup   = (r_older == r_newer) || (r_newer == i_vertex_index) ||
                  (r_older == i_vertex_index);
        w_range = index_ok(r_older, i_vertex_count) && index_ok(r_newer, i_vertex_count) &&
                  index_ok(i_vertex_index, i_vertex_count);
        w_keep  = (w_fill == 2'd2) && !w_dup && w_range;

        o_push.valid = i_accept && w_keep;
        o_push.vtx.a = r_older;
        o_push.vtx.b = w_odd ? i_vertex_index : r_newer;
        o_push.vtx.c = w_odd ? r_newer : i_vertex_index;

        n_older = r_older;
        n_newer = r_newer;
        n_fill  = r_fill;
        n_odd   = r_odd;
        if (i_accept) begin
            n_older = r_newer;
            n_newer = i_vertex_index;
            n_fill  = (w_fill == 2'd2) ? 2'd2 : w_fill + 2'd1;
            // rejected triangles still advance the parity
            n_odd   = (w_fill == 2'd2) ? !w_odd : w_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older <= '0;
            r_newer <= '0;
            r_fill  <= 2'd0;
            r_odd   <= 1'b0;
        end else begin
            r_older <= n_older;
            r_newer <= n_newer;
            r_fill  <= n_fill;
            r_odd   <= n_odd;
        end
    end

endmodule

/* rtl/core/tstl_queue.sv */
module tstl_queue #(
    parameter int DEPTH = tstl_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tstl_pkg::t_push i_push,
    input  logic            i_pop,
    output tstl_pkg::t_head o_head,
    output logic            o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tstl_pkg::t_vtx r_mem [DEPTH];
    logic [PW-1:0]  r_wr, n_wr;
    logic [PW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push.valid) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push.valid && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push.valid && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
        o_head.avail = (r_cnt != '0);
        o_head.vtx   = r_mem[r_rd];
        o_full       = (r_cnt == CW'(DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.vtx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/core/tstl_back.sv */
module tstl_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tstl_pkg::t_head            i_head,
    output logic                       o_pop,
    input  logic [tstl_pkg::IDX_W-1:0] i_base_offset,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [tstl_pkg::IDX_W-1:0] o_m_tdata,
    output logic                       o_m_tlast
);

    logic                       r_valid, n_valid;
    logic [tstl_pkg::IDX_W-1:0] r_data, n_data;
    logic                       r_last, n_last;
    logic [tstl_pkg::IDX_W-1:0] r_b, n_b;
    logic [tstl_pkg::IDX_W-1:0] r_c, n_c;
    logic [1:0]                 r_left, n_left;
    logic                       w_load;

    always_comb begin
        w_load  = !r_valid || i_m_tready;
        o_pop   = w_load && (r_left == 2'd0) && i_head.avail;
        n_valid = r_valid;
        n_data  = r_data;
        n_last  = r_last;
        n_b     = r_b;
        n_c     = r_c;
        n_left  = r_left;
        if (w_load) begin
            if (r_left != 2'd0) begin
                // advance through the rest of the triangle
                n_valid = 1'b1;
                n_data  = r_b + i_base_offset;
                n_last  = (r_left == 2'd1);
                n_b     = r_c;
                n_left  = r_left - 2'd1;
            end else if (i_head.avail) begin
                n_valid = 1'b1;
                n_data  = i_head.vtx.a + i_base_offset;
                n_last  = 1'b0;
                n_b     = i_head.vtx.b;
                n_c     = i_head.vtx.c;
                n_left  = 2'd2;
            end else begin
                n_valid = 1'b0;
            end
        end
        o_m_tvalid = r_valid;
        o_m_tdata  = r_data;
        o_m_tlast  = r_last;
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_last <= n_last;
        r_b    <= n_b;
        r_c    <= n_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_left  <= n_left;
        end
    end

endmodule

/* rtl/core/triangle_strip_to_list.sv */
// Order: a kept triangle is pushed into the triangle queue when its third strip index
// is accepted, then its first index is loaded into the output register; the other two follow.
// Throughput: one strip index per cycle while the triangle queue has room;
// a kept triangle occupies the single-word output register for its three list words.
// Reset clears the strip window, fill and parity, the queue, the output
// register's valid flag and both configuration registers.
module triangle_strip_to_list #(
    parameter int QUEUE_DEPTH = tstl_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tstl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tstl_pkg::IDX_W-1:0]        i_cfg_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [31:0]                       i_s_tdata,  // [31:0] vertex_index
    input  logic [0:0]                        i_s_tuser,  // [0] strip_start
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [31:0]                       o_m_tdata,  // [31:0] list_index
    output logic                              o_m_tlast
);

    logic [tstl_pkg::VCOUNT_W-1:0] r_vertex_count;
    logic [tstl_pkg::IDX_W-1:0]    r_base_offset;

    tstl_pkg::t_push w_push;
    tstl_pkg::t_head w_head;
    logic            w_full;
    logic            w_pop;
    logic            w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_base_offset  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tstl_pkg::CFG_VERTEX_COUNT) begin
                r_vertex_count <= i_cfg_data[tstl_pkg::VCOUNT_W-1:0];
            end else if (i_cfg_idx == tstl_pkg::CFG_BASE_OFFSET) begin
                r_base_offset <= i_cfg_data;
            end
        end
    end

    assign o_s_tready = !w_full;
    assign w_accept   = i_s_tvalid && o_s_tready;

    tstl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_vertex_index (i_s_tdata),
        .i_strip_start  (i_s_tuser[0]),
        .i_vertex_count (r_vertex_count),
        .o_push         (w_push)
    );

    tstl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full)
    );

    tstl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_base_offset (r_base_offset),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast)
    );

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> !w_full)
        else $error("triangle pushed into a full queue");

    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.avail)
        else $error("pop from an empty queue");

    a_no_gap_in_triangle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> o_m_tvalid)
        else $error("gap inside a triangle");

endmodule

/* sim/triangle_list_checker.sv */
`timescale 1ns / 100ps

module triangle_list_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tstl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tstl_pkg::IDX_W-1:0]    i_cfg_data,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [31:0]                   i_s_tdata,   // [31:0] vertex_index
    input  logic [0:0]                    i_s_tuser,   // [0] strip_start
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [31:0]                   i_m_tdata,   // [31:0] list_index
    input  logic                          i_m_tlast,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_indices_seen,
    output int                            o_words_checked
);

    typedef struct packed {
        logic [tstl_pkg::IDX_W-1:0] index;
        logic                       last;
    } t_list_word;

    t_list_word expected_words[$];

    logic [tstl_pkg::VCOUNT_W-1:0] vertex_count;
    logic [tstl_pkg::IDX_W-1:0]    base_offset;
    logic [tstl_pkg::IDX_W-1:0]    older_index;
    logic [tstl_pkg::IDX_W-1:0]    newer_index;
    logic [1:0]                    strip_fill;
    logic                          odd_position;

    int error_count;
    int index_count;
    int word_count;

    function automatic logic index_in_range(input logic [tstl_pkg::IDX_W-1:0] v);
        return !v[tstl_pkg::IDX_W-1] && (v[tstl_pkg::VCOUNT_W-1:0] < vertex_count);
    endfunction

    task automatic queue_word(input logic [tstl_pkg::IDX_W-1:0] v, input logic last);
        t_list_word w;
        w.index = v + base_offset;
        w.last  = last;
        expected_words = {expected_words, w};
    endtask

    // advance the strip window by one index and queue any triangle it closes
    task automatic accept_strip_index(input logic [tstl_pkg::IDX_W-1:0] cur,
                                      input logic start);
        logic [tstl_pkg::IDX_W-1:0] a;
        logic [tstl_pkg::IDX_W-1:0] b;
        logic [tstl_pkg::IDX_W-1:0] c;
        logic [tstl_pkg::IDX_W-1:0] t;
        logic                       keep;
        if (start) begin
            strip_fill   = 2'd0;
            odd_position = 1'b0;
        end
        if (strip_fill >= 2'd2) begin
            a = older_index;
            b = newer_index;
            c = cur;
            keep = (a != b) && (b != c) && (a != c) &&
                   index_in_range(a) && index_in_range(b) && index_in_range(c);
            if (keep) begin
                // odd start position: swap b and c to keep the winding
                if (odd_position) begin
                    t = b;
                    b = c;
                    c = t;
                end
                queue_word(a, 1'b0);
                queue_word(b, 1'b0);
                queue_word(c, 1'b1);
            end
            odd_position = ~odd_position;
        end
        older_index = newer_index;
        newer_index = cur;
        if (strip_fill < 2'd2) strip_fill = strip_fill + 2'd1;
    endtask

    always @(posedge i_clk) begin
        t_list_word want;
        if (!i_rst_n) begin
            vertex_count = '0;
            base_offset  = '0;
            older_index  = '0;
            newer_index  = '0;
            strip_fill   = 2'd0;
            odd_position = 1'b0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tstl_pkg::CFG_VERTEX_COUNT:
                        vertex_count = i_cfg_data[tstl_pkg::VCOUNT_W-1:0];
                    tstl_pkg::CFG_BASE_OFFSET:
                        base_offset  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected list word: list_index %h triangle_end %b",
                           i_m_tdata, i_m_tlast);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    word_count++;
                    if (i_m_tdata !== want.index) begin
                        $error("list_index: expected %h, got %h", want.index, i_m_tdata);
                        error_count++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("triangle_end: expected %b, got %b", want.last, i_m_tlast);
                        error_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                accept_strip_index(i_s_tdata, i_s_tuser[0]);
                index_count++;
            end
        end
        o_pending       <= expected_words.size();
        o_errors        <= error_count;
        o_indices_seen  <= index_count;
        o_words_checked <= word_count;
    end

endmodule

/* sim/triangle_strip_to_list_tb.sv */
`timescale 1ns / 100ps

module triangle_strip_to_list_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 250;
    localparam int TAIL_CYCLES = 8;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [tstl_pkg::CFG_IDX_W-1:0] cfg_idx = tstl_pkg::CFG_VERTEX_COUNT;
    logic [tstl_pkg::IDX_W-1:0]     cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [31:0]                    s_tdata = '0;
    logic [0:0]                     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [31:0]                    m_tdata;
    logic                           m_tlast;

    int errors;
    int pending;
    int indices_seen;
    int words_checked;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int settings_count = 0;
    logic [31:0] cur_vcount = '0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    triangle_strip_to_list DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    triangle_list_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tlast       (m_tlast),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_indices_seen  (indices_seen),
        .o_words_checked (words_checked)
    );

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d list words still due",
                     cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 67; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            IDLE_BOTH:     begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            default: ;
        endcase
    endtask

    task automatic send_index(input logic [31:0] v, input logic start);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= v;
        s_tuser[0] <= start;
        do @(posedge clk); while (!(s_tvalid && s_tready));
    endtask

    // drop valid, wait for every queued word, then let in-flight work settle
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [tstl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic apply_settings(input logic [31:0] vcount, input logic [31:0] offset);
        wait_drained();
        write_reg(tstl_pkg::CFG_VERTEX_COUNT, vcount);
        write_reg(tstl_pkg::CFG_BASE_OFFSET, offset);
        cur_vcount = vcount & 32'h7FFF_FFFF;
        settings_count++;
    endtask

    // mostly in-range indices; some repeats, negatives and out-of-range values
    function automatic logic [31:0] pick_index(input logic [31:0] a, input logic [31:0] b);
        int r;
        r = $urandom_range(99);
        if (r < 72)
            return (cur_vcount == 0) ? 32'($urandom_range(15)) : $urandom % cur_vcount;
        else if (r < 84)
            return r[0] ? a : b;
        else if (r < 91)
            return $urandom | 32'h8000_0000;
        else if (r < 96)
            return cur_vcount + 32'($urandom_range(2));
        else
            return $urandom;
    endfunction

    task automatic send_strips(input int n_items, input int pause_at);
        int left;
        int len;
        logic first_start;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] v;
        left = n_items;
        a = '0;
        b = '0;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            if (len > left) len = left;
            first_start = ($urandom_range(9) != 0);
            for (int k = 0; k < len; k++) begin
                v = pick_index(a, b);
                send_index(v, (k == 0) ? first_start : ($urandom_range(49) == 0));
                a = b;
                b = v;
                left--;
                if (n_items - left == pause_at) wait_drained();
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        set_idle_mode(IDLE_NONE);

        // registers still at reset: no strip start yet, zero vertex count
        send_index(32'd5, 1'b0);
        send_index(32'd6, 1'b0);
        send_index(32'd7, 1'b0);

        apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFF0);
        // plain strip: second triangle gets b and c swapped
        send_index(32'd0, 1'b1);
        send_index(32'd1, 1'b0);
        send_index(32'd2, 1'b0);
        send_index(32'd3, 1'b0);
        // top of the range; rejected triangles still flip the parity
        send_index(32'h7FFF_FFFE, 1'b1);
        send_index(32'h7FFF_FFFF, 1'b0);
        send_index(32'h7FFF_FFFD, 1'b0);
        send_index(32'd0, 1'b0);
        send_index(32'd1, 1'b0);
        // negative indices
        send_index(32'd10, 1'b1);
        send_index(32'h8000_0000, 1'b0);
        send_index(32'hFFFF_FFFF, 1'b0);
        send_index(32'd12, 1'b0);
        // repeated index
        send_index(32'd4, 1'b1);
        send_index(32'd4, 1'b0);
        send_index(32'd5, 1'b0);
        send_index(32'd6, 1'b0);
        // strip too short, then a fresh one
        send_index(32'd7, 1'b1);
        send_index(32'd8, 1'b0);
        send_index(32'd20, 1'b1);
        send_index(32'd21, 1'b0);
        send_index(32'd22, 1'b0);

        apply_settings(32'd16, 32'd0);
        set_idle_mode(IDLE_NONE);
        send_strips(30, 0);

        apply_settings(32'd1000, $urandom);
        set_idle_mode(IDLE_SENDER);
        send_strips(30, 17);

        apply_settings(32'd3, 32'hFFFF_FFFF);
        set_idle_mode(IDLE_RECEIVER);
        send_strips(30, 0);

        apply_settings(32'h7FFF_FFFF, 32'h8000_0000);
        set_idle_mode(IDLE_BOTH);
        send_strips(30, 0);

        apply_settings(32'd0, 32'd7);
        set_idle_mode(IDLE_SENDER);
        send_strips(10, 0);

        // long receiver hold-off while the sender keeps pushing: fill the queue
        apply_settings(32'd64, $urandom);
        set_idle_mode(IDLE_NONE);
        hold_token = hold_token + 1;
        send_strips(30, 0);

        apply_settings(32'($urandom_range(4, 200)), $urandom);
        set_idle_mode(IDLE_RECEIVER);
        send_strips(30, 20);

        wait_drained();
        $display("covered %0d strip indices and %0d checked list words (%0d triangles)",
                 indices_seen, words_checked, words_checked / 3);
        $display("across %0d register settings, all idle modes and a full-queue stall",
                 settings_count);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/tstl_pkg.sv
rtl/core/tstl_front.sv
rtl/core/tstl_queue.sv
rtl/core/tstl_back.sv
rtl/core/triangle_strip_to_list.sv
sim/triangle_list_checker.sv
sim/triangle_strip_to_list_tb.sv
